/* src/vector_distance_engine_assert.svh */
// Assertion macros for the vector distance engine.
`ifndef VECTOR_DISTANCE_ENGINE_ASSERT_SVH
`define VECTOR_DISTANCE_ENGINE_ASSERT_SVH
`ifndef SYNTH
`define VDE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define VDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define VDE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VDE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/vde_pkg.sv */
// Types, constants and helper functions shared by the vector distance engine.
package vde_pkg;
  localparam int ELEM_W     = 16;
  localparam int ACC_W      = 48;
  localparam int OUT_W      = 48;
  localparam int FRAC_SHIFT = 12;
  localparam int OUT_SHIFT  = 8;
  localparam int ONE_Q16    = 65536;
  localparam int Q_W        = 17;
  localparam int HALF_W     = ACC_W / 2;
  localparam int RAD_W      = 2 * ACC_W;
  localparam int ROOT_W     = ACC_W;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int DIV_STEPS  = 16;
  localparam int MUL_STEPS  = 4;
  localparam int CNT_W      = 6;
  localparam int MODE_W     = 3;

  localparam logic [MODE_W-1:0] MODE_L2   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COS  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DOT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_L1   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NORM = 3'd4;

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] distance;
    logic                    result_valid;
  } out_item_t;

  typedef struct packed {
    logic       take;
    logic       acc;
    logic       mul_step;
    logic [1:0] mul_sel;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_step;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              last;
    logic              out_free;
  } status_t;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    logic signed [ACC_W-1:0] res;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      res = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      res = s[ACC_W-1:0];
    end
    return res;
  endfunction
endpackage

/* src/vde_ctrl.sv */
// Controller state machine that sequences accumulation and the final result steps.
module vde_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  vde_pkg::status_t st,
  output vde_pkg::cmd_t    cmd
);
  import vde_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SINIT = 3'd3;
  localparam logic [2:0] S_SQRT  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        cnt_nxt = '0;
        if (!st.last) begin
          state_nxt = S_IDLE;
        end else begin
          case (st.mode) inside
            MODE_L2, MODE_NORM: state_nxt = S_SINIT;
            MODE_COS:           state_nxt = S_MUL;
            default:            state_nxt = S_FIN;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.mul_sel  = cnt_r[1:0];
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          state_nxt = S_SINIT;
        end
      end
      S_SINIT: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (st.mode == MODE_COS) ? S_DIV : S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end
endmodule

/* src/vde_datapath.sv */
// Datapath: term products, saturating sums, shared root and divide units, result register.
module vde_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [vde_pkg::MODE_W-1:0]    cfg_data,
  input  vde_pkg::in_item_t             in_item,
  input  vde_pkg::cmd_t                 cmd,
  output vde_pkg::status_t              st,
  output logic                          out_valid,
  input  logic                          out_ready,
  output vde_pkg::out_item_t            out_item
);
  import vde_pkg::*;

  logic [MODE_W-1:0]        mode_r;
  logic signed [ACC_W-1:0]  main_r, na_r, nb_r;
  logic signed [ACC_W-1:0]  tmain_r, ta_r, tb_r, tmain_nxt;
  logic                     last_r;
  logic [RAD_W-1:0]         prod_r, rad_r, pp_ext;
  logic [ROOT_W-1:0]        root_r;
  logic [ROOT_W+1:0]        srem_r;
  logic [ACC_W:0]           drem_r;
  logic [Q_W-1:0]           q_r, qf;
  logic                     out_valid_r;
  out_item_t                out_r, fin_item;

  logic signed [ELEM_W:0]     diff;
  logic [ELEM_W:0]            mdiff;
  logic signed [2*ELEM_W-1:0] sq_a, sq_b, prod_ab;
  logic signed [2*ELEM_W+1:0] sq_d;
  logic [HALF_W-1:0]          ua, ub;
  logic [2*HALF_W-1:0]        pp;
  logic signed [ACC_W-1:0]    main_pos;
  logic [ACC_W-1:0]           mag;
  logic [ROOT_W+3:0]          t, trial;
  logic [ACC_W+1:0]           r2, den;
  logic                       ge, zero_norm;

  assign diff    = {in_item.elem_a[ELEM_W-1], in_item.elem_a}
                 - {in_item.elem_b[ELEM_W-1], in_item.elem_b};
  assign mdiff   = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : diff;
  assign sq_a    = in_item.elem_a * in_item.elem_a;
  assign sq_b    = in_item.elem_b * in_item.elem_b;
  assign prod_ab = in_item.elem_a * in_item.elem_b;
  assign sq_d    = diff * diff;

  always_comb begin
    unique case (mode_r)
      MODE_L2:            tmain_nxt = ACC_W'(sq_d);
      MODE_COS, MODE_DOT: tmain_nxt = ACC_W'(prod_ab);
      MODE_L1:            tmain_nxt = ACC_W'({mdiff, {FRAC_SHIFT{1'b0}}});
      MODE_NORM:          tmain_nxt = ACC_W'(sq_a);
      default:            tmain_nxt = '0;
    endcase
  end

  assign ua = cmd.mul_sel[0] ? na_r[ACC_W-1:HALF_W] : na_r[HALF_W-1:0];
  assign ub = cmd.mul_sel[1] ? nb_r[ACC_W-1:HALF_W] : nb_r[HALF_W-1:0];
  assign pp = ua * ub;

  always_comb begin
    case (cmd.mul_sel) inside
      2'd0:       pp_ext = RAD_W'(pp);
      2'd1, 2'd2: pp_ext = RAD_W'({pp, {HALF_W{1'b0}}});
      default:    pp_ext = {pp, {(2*HALF_W){1'b0}}};
    endcase
  end

  assign main_pos = main_r[ACC_W-1] ? '0 : main_r;
  assign mag      = main_r[ACC_W-1] ? ACC_W'(-main_r) : main_r;
  assign t        = {srem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign r2       = {drem_r, 1'b0};
  assign den      = {2'b00, root_r};

  assign ge        = (mag >= root_r);
  assign qf        = ge ? Q_W'(ONE_Q16) : q_r;
  assign zero_norm = (na_r == '0) || (nb_r == '0);

  always_comb begin
    fin_item.result_valid = 1'b1;
    unique case (mode_r)
      MODE_L2, MODE_NORM: fin_item.distance = OUT_W'(root_r);
      MODE_COS: begin
        if (zero_norm) begin
          fin_item.distance     = '0;
          fin_item.result_valid = 1'b0;
        end else if (main_r[ACC_W-1]) begin
          fin_item.distance = OUT_W'(ONE_Q16) + OUT_W'(qf);
        end else begin
          fin_item.distance = OUT_W'(ONE_Q16) - OUT_W'(qf);
        end
      end
      MODE_DOT, MODE_L1: fin_item.distance = OUT_W'(main_r >>> OUT_SHIFT);
      default: begin
        fin_item.distance     = '0;
        fin_item.result_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_L2;
      main_r      <= '0;
      na_r        <= '0;
      nb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode_r <= cfg_data;
      end
      if (cmd.acc) begin
        main_r <= sat_add(main_r, tmain_r);
        na_r   <= sat_add(na_r, ta_r);
        nb_r   <= sat_add(nb_r, tb_r);
      end else if (cmd.finish) begin
        main_r <= '0;
        na_r   <= '0;
        nb_r   <= '0;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      tmain_r <= tmain_nxt;
      ta_r    <= ACC_W'(sq_a);
      tb_r    <= ACC_W'(sq_b);
      last_r  <= in_item.last_element;
    end
    if (cmd.acc) begin
      prod_r <= '0;
    end else if (cmd.mul_step) begin
      prod_r <= prod_r + pp_ext;
    end
    if (cmd.sqrt_init) begin
      rad_r  <= (mode_r == MODE_COS) ? prod_r : RAD_W'({main_pos, {OUT_SHIFT{1'b0}}});
      root_r <= '0;
      srem_r <= '0;
      drem_r <= {1'b0, mag};
      q_r    <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (t >= trial) begin
        srem_r <= (ROOT_W+2)'(t - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        srem_r <= t[ROOT_W+1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end else if (cmd.div_step) begin
      if (r2 >= den) begin
        drem_r <= (ACC_W+1)'(r2 - den);
        q_r    <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        drem_r <= r2[ACC_W:0];
        q_r    <= {q_r[Q_W-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      out_r <= fin_item;
    end
  end

  assign st.mode     = mode_r;
  assign st.last     = last_r;
  assign st.out_free = !out_valid_r || out_ready;
  assign out_valid   = out_valid_r;
  assign out_item    = out_r;
endmodule

/* src/vector_distance_engine.sv */
// Top level of the vector distance engine: controller, datapath and checks.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_data (elem_a, elem_b, last_element)
//   out_     output     out_valid/out_ready  out_data (distance, result_valid)
//   cfg_     input      cfg_valid/cfg_ready  cfg_data (distance_mode)
//
// Each element pair has its products formed and registered before the saturating adds.
// A last element then adds the finish: dot and L1 need no further steps, L2 and norm
// use the 48-step shared root unit, cosine 4 partial products, root, 16-step divide.
// Reset clears the mode, the sums and the result valid flag; there is no clearing pass.
// A waiting result holds in the output register; the next vector may stream meanwhile.
`include "vector_distance_engine_assert.svh"
module vector_distance_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  vde_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output vde_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [vde_pkg::MODE_W-1:0] cfg_data
);
  import vde_pkg::*;

  cmd_t       cmd;
  status_t    st;
  logic [6:0] cmd_bits;

  assign cfg_ready = 1'b1;
  assign cmd_bits  = {cmd.take, cmd.acc, cmd.mul_step, cmd.sqrt_init, cmd.sqrt_step,
                      cmd.div_step, cmd.finish};

  vde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  vde_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_item   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

  `VDE_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)
  `VDE_ASSERT_NEXT(a_finish_shows, clk, rst_n, cmd.finish, out_valid)
  `VDE_ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd_bits))
endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the vector distance engine with a scoreboard class.
`timescale 1ns / 1ps
module tb;
  import vde_pkg::*;

  localparam longint ACC_HI = 64'sd140737488355327;
  localparam longint ACC_LO = -64'sd140737488355328;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE_CYCLES = 120;

  class dist_scoreboard;
    logic [MODE_W-1:0] mode;
    longint main_sum, norm_a, norm_b;
    out_item_t pending[$];
    int mismatches;

    function new();
      mode = MODE_L2;
      main_sum = 0;
      norm_a = 0;
      norm_b = 0;
      mismatches = 0;
    endfunction

    function longint clamp_acc(longint s);
      if (s > ACC_HI) return ACC_HI;
      if (s < ACC_LO) return ACC_LO;
      return s;
    endfunction

    function logic [63:0] floor_root(logic [127:0] x);
      logic [127:0] rem, root, bitv;
      rem = x;
      root = 0;
      bitv = 128'h1 << 126;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem = rem - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root[63:0];
    endfunction

    function void note_request(in_item_t it);
      longint a, b, ma, mb, md, m, q;
      logic [127:0] prod, num;
      logic [63:0] den;
      out_item_t r;
      a = it.elem_a;
      b = it.elem_b;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      md = (a - b) < 0 ? b - a : a - b;
      norm_a = clamp_acc(norm_a + ma * ma);
      norm_b = clamp_acc(norm_b + mb * mb);
      case (mode)
        MODE_L2: main_sum = clamp_acc(main_sum + md * md);
        MODE_COS, MODE_DOT: main_sum = clamp_acc(main_sum + a * b);
        MODE_L1: main_sum = clamp_acc(main_sum + (md << FRAC_SHIFT));
        MODE_NORM: main_sum = clamp_acc(main_sum + ma * ma);
        default: ;
      endcase
      if (!it.last_element) return;
      r.result_valid = 1'b1;
      r.distance = '0;
      case (mode)
        MODE_L2, MODE_NORM: begin
          num = main_sum < 0 ? 128'd0 : (128'(main_sum) << OUT_SHIFT);
          r.distance = OUT_W'(floor_root(num));
        end
        MODE_COS: begin
          if (norm_a <= 0 || norm_b <= 0) begin
            r.result_valid = 1'b0;
          end else begin
            prod = 128'(norm_a) * 128'(norm_b);
            den = floor_root(prod);
            m = main_sum < 0 ? -main_sum : main_sum;
            if (m >= den) q = ONE_Q16;
            else q = longint'((128'(m) << 16) / 128'(den));
            r.distance = OUT_W'(main_sum < 0 ? ONE_Q16 + q : ONE_Q16 - q);
          end
        end
        MODE_DOT, MODE_L1: r.distance = OUT_W'(main_sum >>> OUT_SHIFT);
        default: r.result_valid = 1'b0;
      endcase
      pending.push_back(r);
      main_sum = 0;
      norm_a = 0;
      norm_b = 0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: distance %0d valid %0d", got.distance, got.result_valid);
        return;
      end
      want = pending.pop_front();
      if (got.distance !== want.distance || got.result_valid !== want.result_valid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected distance %0d valid %0d, got distance %0d valid %0d",
                   want.distance, want.result_valid, got.distance, got.result_valid);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [MODE_W-1:0] cfg_data;

  dist_scoreboard sb;
  int send_gap_max, recv_gap_max, hold_len, total;
  longint cycles;

  vector_distance_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(it);
    total++;
  endtask

  task automatic write_mode(logic [MODE_W-1:0] m);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 4))
      0: return ELEM_W'($urandom_range(0, 64) - 32);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      2: return 16'h0000;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic send_pair(int a, int b, bit last);
    in_item_t it;
    it.elem_a = ELEM_W'(a);
    it.elem_b = ELEM_W'(b);
    it.last_element = last;
    send_item(it);
  endtask

  always begin
    int n;
    @(negedge clk);
    n = $urandom_range(0, recv_gap_max) + hold_len;
    hold_len = 0;
    if (n > 0) begin
      out_ready <= 1'b0;
      repeat (n) @(negedge clk);
    end
    out_ready <= 1'b1;
    @(posedge clk);
    while (!out_valid) @(posedge clk);
    sb.check_result(out_data);
  end

  initial begin
    in_item_t it;
    int len, cnt, m;
    sb = new();
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_gap_max = 17;
    recv_gap_max = 17;
    hold_len = 0;
    total = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (m = 0; m < 8; m++) begin
      write_mode(MODE_W'(m));
      if (m < 5) begin
        send_pair(-32768, 32767, 0);
        send_pair(32767, -32768, 1);
        send_pair(-32768, -32768, 1);
      end
      send_pair(0, 0, 1);
      drain();
    end
    write_mode(MODE_COS);
    send_pair(1000, 1000, 0);
    send_pair(-3, 7, 1);
    send_pair(0, 500, 1);
    drain();

    // Long vector of extreme differences at full input rate.
    write_mode(MODE_L2);
    send_gap_max = 0;
    recv_gap_max = 0;
    for (cnt = 0; cnt < 64; cnt++)
      send_pair(cnt[0] ? -32768 : 32767, cnt[0] ? 32767 : -32768, cnt == 63);
    drain();

    // Receiver holds off while short dot-product vectors keep arriving.
    send_gap_max = 0;
    write_mode(MODE_DOT);
    hold_len = 600;
    for (cnt = 0; cnt < 60; cnt++) begin
      it.elem_a = rand_elem();
      it.elem_b = rand_elem();
      it.last_element = 1'b1;
      send_item(it);
    end
    drain();

    while (total < 1350) begin
      send_gap_max = $urandom_range(0, 3) == 0 ? 0 : 17;
      recv_gap_max = $urandom_range(0, 3) == 0 ? 0 : 17;
      write_mode(MODE_W'($urandom_range(0, 9) == 0 ? $urandom_range(5, 7)
                                                   : $urandom_range(0, 4)));
      cnt = $urandom_range(40, 150);
      len = 0;
      while (cnt > 0) begin
        if (len == 0) len = $urandom_range(0, 5) == 0 ? $urandom_range(9, 40)
                                                       : $urandom_range(1, 8);
        it.elem_a = rand_elem();
        it.elem_b = rand_elem();
        len--;
        cnt--;
        it.last_element = (len == 0) && (cnt > 0 || $urandom_range(0, 2) != 0);
        send_item(it);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+src
src/vde_pkg.sv
src/vde_ctrl.sv
src/vde_datapath.sv
src/vector_distance_engine.sv
tb/sv/tb.sv
